### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define TWP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define TWP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/twp_pkg.sv
// Shared constants, register indexes and control structs of the waveform player.
package twp_pkg;

   // Waveform memory geometry.
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WORD_W = 32;

   // Field widths.
   localparam int SAMPLE_W  = 16;
   localparam int POS_W     = 11;
   localparam int AMPS_W    = 9;
   localparam int AMP_IDX_W = 8;

   // Arithmetic widths: step product, gain and gain times sample.
   localparam int PROD_W = AMPS_W + SAMPLE_W;
   localparam int GAIN_W = PROD_W + 1;
   localparam int MUL_W  = GAIN_W + SAMPLE_W;
   localparam int FRAC_SHIFT = 12;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_AMP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_AMP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_AMPS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 3'd4;

   // Input item kinds carried in tuser.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_ACTIVE_BIT = 2 * SAMPLE_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick_accept;
      logic load_accept;
      logic gain_en;
      logic mul_en;
      logic out_en;
   } twp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_stall;
   } twp_status_type;

endpackage

### rtl/core/twp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/twp_ctrl.sv
// Sequencer of the waveform player: takes items and steps the datapath.
module twp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_mode,
   input  twp_pkg::twp_status_type status,
   output logic                    req_tready,
   output twp_pkg::twp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GAIN = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       take;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && (req_mode == twp_pkg::MODE_LOAD)) begin
               cmd.load_accept = 1'b1;
            end else if (take) begin
               cmd.tick_accept = 1'b1;
               state_in        = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.gain_en = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_stall) begin
               cmd.out_en = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/twp_datapath.sv
// Datapath of the waveform player: registers, play state, memory and scaling.
module twp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  twp_pkg::twp_cmd_type                   cmd,
   output twp_pkg::twp_status_type                status,
   input  logic signed [twp_pkg::SAMPLE_W-1:0]    trigger_sample,
   input  logic [twp_pkg::ADDR_W-1:0]             load_address,
   input  logic signed [twp_pkg::SAMPLE_W-1:0]    load_re,
   input  logic signed [twp_pkg::SAMPLE_W-1:0]    load_im,
   input  logic                                   csr_we,
   input  logic [twp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [twp_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [twp_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam logic [twp_pkg::POS_W-1:0]  POS_IDLE = twp_pkg::POS_W'(twp_pkg::DEPTH);
   localparam logic [twp_pkg::AMPS_W-1:0] AMPS_MAX = twp_pkg::AMPS_W'(256);
   localparam logic signed [twp_pkg::MUL_W-1:0] SAT_HI =
      twp_pkg::MUL_W'((1 << (twp_pkg::SAMPLE_W - 1)) - 1);
   localparam logic signed [twp_pkg::MUL_W-1:0] SAT_LO = -SAT_HI - twp_pkg::MUL_W'(1);

   // Configuration registers, lengths stored already clamped.
   logic [twp_pkg::POS_W-1:0]           wave_len_ff;
   logic signed [twp_pkg::SAMPLE_W-1:0] start_amp_ff;
   logic signed [twp_pkg::SAMPLE_W-1:0] delta_amp_ff;
   logic [twp_pkg::AMPS_W-1:0]          num_amps_ff;
   logic signed [twp_pkg::SAMPLE_W-1:0] threshold_ff;

   // Player state.
   logic [twp_pkg::POS_W-1:0]     play_pos_ff, play_pos_in;
   logic [twp_pkg::AMP_IDX_W-1:0] amp_index_ff, amp_index_in;
   logic                          prev_high_ff, prev_high_in;

   // Pipeline registers.
   logic signed [twp_pkg::PROD_W-1:0] prod_ff;
   logic signed [twp_pkg::GAIN_W-1:0] gain_ff;
   logic signed [twp_pkg::MUL_W-1:0]  mul_re_ff, mul_im_ff;
   logic                              act_ff;
   logic                              rsp_valid_ff;
   logic [twp_pkg::RSP_TDATA_W-1:0]   rsp_data_ff;

   logic                          restart;
   logic                          csr_known;
   logic                          high;
   logic [twp_pkg::POS_W-1:0]     pos_cur, pos_next;
   logic                          play;
   logic [twp_pkg::AMPS_W-1:0]    amp_next;
   logic [twp_pkg::POS_W-1:0]     len_wr;
   logic [twp_pkg::AMPS_W-1:0]    amps_wr;
   logic [twp_pkg::WORD_W-1:0]    ram_rdata;
   logic [twp_pkg::SAMPLE_W-1:0]  sat_re, sat_im;

   // Floor shift of a Q.27 product back to Q.15, then saturation.
   function automatic logic [twp_pkg::SAMPLE_W-1:0] scale_sat(
      input logic signed [twp_pkg::MUL_W-1:0] p
   );
      logic signed [twp_pkg::MUL_W-1:0] s;
      s = p >>> twp_pkg::FRAC_SHIFT;
      if (s > SAT_HI) begin
         return SAT_HI[twp_pkg::SAMPLE_W-1:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[twp_pkg::SAMPLE_W-1:0];
      end
      return s[twp_pkg::SAMPLE_W-1:0];
   endfunction

   // Register writes: only listed indexes restart the player.
   always_comb begin
      unique case (csr_index)
         twp_pkg::CSR_WAVE_LENGTH, twp_pkg::CSR_START_AMP, twp_pkg::CSR_DELTA_AMP,
         twp_pkg::CSR_NUM_AMPS, twp_pkg::CSR_THRESHOLD: csr_known = 1'b1;
         default: csr_known = 1'b0;
      endcase
   end

   assign restart = cmd.load_accept || (csr_we && csr_known);

   // Clamp the length to the memory depth and the step count to 1..256.
   always_comb begin
      if (csr_wdata[twp_pkg::POS_W-1:0] > POS_IDLE) begin
         len_wr = POS_IDLE;
      end else begin
         len_wr = csr_wdata[twp_pkg::POS_W-1:0];
      end
      if (csr_wdata[twp_pkg::AMPS_W-1:0] == '0) begin
         amps_wr = twp_pkg::AMPS_W'(1);
      end else if (csr_wdata[twp_pkg::AMPS_W-1:0] > AMPS_MAX) begin
         amps_wr = AMPS_MAX;
      end else begin
         amps_wr = csr_wdata[twp_pkg::AMPS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_len_ff  <= '0;
         start_amp_ff <= 16'sd4096;
         delta_amp_ff <= '0;
         num_amps_ff  <= twp_pkg::AMPS_W'(1);
         threshold_ff <= 16'sd2048;
      end else if (csr_we) begin
         unique case (csr_index)
            twp_pkg::CSR_WAVE_LENGTH: wave_len_ff  <= len_wr;
            twp_pkg::CSR_START_AMP:   start_amp_ff <= $signed(csr_wdata);
            twp_pkg::CSR_DELTA_AMP:   delta_amp_ff <= $signed(csr_wdata);
            twp_pkg::CSR_NUM_AMPS:    num_amps_ff  <= amps_wr;
            twp_pkg::CSR_THRESHOLD:   threshold_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Trigger edge, play decision and position advance for a tick.
   assign high     = trigger_sample > threshold_ff;
   assign pos_cur  = (high && !prev_high_ff) ? '0 : play_pos_ff;
   assign play     = pos_cur < wave_len_ff;
   assign pos_next = pos_cur + twp_pkg::POS_W'(1);
   assign amp_next = {1'b0, amp_index_ff} + twp_pkg::AMPS_W'(1);

   always_comb begin
      play_pos_in  = play_pos_ff;
      amp_index_in = amp_index_ff;
      prev_high_in = prev_high_ff;
      priority if (restart) begin
         play_pos_in  = POS_IDLE;
         amp_index_in = '0;
         prev_high_in = 1'b0;
      end else if (cmd.tick_accept) begin
         prev_high_in = high;
         play_pos_in  = play ? pos_next : pos_cur;
         if (play && (pos_next == wave_len_ff)) begin
            amp_index_in = (amp_next == num_amps_ff) ? '0
                                                     : amp_next[twp_pkg::AMP_IDX_W-1:0];
         end
      end else begin
         // No transfer this cycle: the play state holds.
         play_pos_in  = play_pos_ff;
         amp_index_in = amp_index_ff;
         prev_high_in = prev_high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_pos_ff  <= POS_IDLE;
         amp_index_ff <= '0;
         prev_high_ff <= 1'b0;
      end else begin
         play_pos_ff  <= play_pos_in;
         amp_index_ff <= amp_index_in;
         prev_high_ff <= prev_high_in;
      end
   end

   // Waveform memory: imaginary part in the upper half of each word.
   twp_ram #(
      .WIDTH(twp_pkg::WORD_W),
      .DEPTH(twp_pkg::DEPTH)
   ) u_twp_ram (
      .clock(clock),
      .we   (cmd.load_accept),
      .waddr(load_address),
      .wdata({load_im, load_re}),
      .re   (cmd.tick_accept && play),
      .raddr(pos_cur[twp_pkg::ADDR_W-1:0]),
      .rdata(ram_rdata)
   );

   // Gain pipeline: step product, then gain, then the two sample products.
   always_ff @(posedge clock) begin
      if (cmd.tick_accept) begin
         prod_ff <= $signed({1'b0, amp_index_ff}) * delta_amp_ff;
         act_ff  <= play;
      end
      if (cmd.gain_en) begin
         gain_ff <= twp_pkg::GAIN_W'(start_amp_ff) + twp_pkg::GAIN_W'(prod_ff);
      end
      if (cmd.mul_en) begin
         mul_re_ff <= gain_ff * $signed(ram_rdata[twp_pkg::SAMPLE_W-1:0]);
         mul_im_ff <= gain_ff * $signed(ram_rdata[twp_pkg::WORD_W-1:twp_pkg::SAMPLE_W]);
      end
   end

   assign sat_re = act_ff ? scale_sat(mul_re_ff) : '0;
   assign sat_im = act_ff ? scale_sat(mul_im_ff) : '0;

   // Output register holds a result until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_en) begin
         rsp_data_ff <= twp_pkg::RSP_TDATA_W'({amp_index_ff, act_ff, sat_im, sat_re});
      end
   end

   assign status.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

endmodule

### rtl/core/triggered_waveform_player_unit.sv
// Top level of the triggered waveform player: stream ports, controller and datapath.
// A tick transfer runs the memory read and step product, the gain add, the sample multiply, then shift
// and saturate into the output register, whereupon rsp_tvalid rises; a stalled output holds the last
// step. The four-step sequencer takes no new item until a tick has passed all its steps; a load item
// leaves the sequencer idle and ready. Reset is synchronous and restores the register defaults
// and the idle player; the waveform memory is undefined until loaded.
module triggered_waveform_player_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: trigger_sample[15:0], load_address[25:16], load_re[41:26], load_im[57:42]
   input  logic [twp_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // tuser: mode[0]
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: out_re[15:0], out_im[31:16], active[32], amp_step[40:33]
   output logic [twp_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [twp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [twp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   twp_pkg::twp_cmd_type    cmd;
   twp_pkg::twp_status_type status;

   twp_ctrl u_twp_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_mode  (req_tuser),
      .status    (status),
      .req_tready(req_tready),
      .cmd       (cmd)
   );

   twp_datapath u_twp_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .trigger_sample($signed(req_tdata[15:0])),
      .load_address  (req_tdata[25:16]),
      .load_re       ($signed(req_tdata[41:26])),
      .load_im       ($signed(req_tdata[57:42])),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

### rtl/core/twp_checker.sv
// Port-level assertions for the triggered waveform player, bound to the top level.
`include "assert_macros.svh"

module twp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [twp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic tick_xfer;
   logic load_xfer;

   assign tick_xfer = req_tvalid && req_tready && (req_tuser == twp_pkg::MODE_TICK);
   assign load_xfer = req_tvalid && req_tready && (req_tuser == twp_pkg::MODE_LOAD);

   // A result waiting for its transfer stays put.
   `TWP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   // A load leaves the sequencer idle, so the input side is open again in the next cycle.
   `TWP_ASSERT_NXT(a_load_one_cycle, clock, reset, load_xfer, req_tready, "not ready after a load transfer")
   // A tick occupies the sequencer, so the next cycle takes no input.
   `TWP_ASSERT_NXT(a_tick_busy, clock, reset, tick_xfer, !req_tready, "input taken while a tick is in work")
   // An idle result carries zero samples.
   `TWP_ASSERT_IMP(a_idle_zero, clock, reset, rsp_tvalid && !rsp_tdata[twp_pkg::RSP_ACTIVE_BIT], rsp_tdata[twp_pkg::RSP_ACTIVE_BIT-1:0] == '0, "idle result with nonzero samples")

endmodule

bind triggered_waveform_player_unit twp_checker u_twp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
